/* hdl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clk edge outside reset
`define MPC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// antecedent holds, consequent must hold in the cycle after
`define MPC_ASSERT_NEXT(label, ante, cons, msg) \
	`MPC_ASSERT(label, (ante) |=> (cons), msg)

`endif

/* hdl/mpc_pkg.sv */
package mpc_pkg;

	localparam int SCORE_W    = 16;
	localparam int DEV_W      = 17;
	localparam int SQ_W       = 64;
	localparam int SQ_STEPS   = SQ_W / 2;
	localparam int SQ_CNT_W   = $clog2(SQ_STEPS);
	localparam int DIV_N      = 80;
	localparam int DEN_W      = 64;
	localparam int DIV_CNT_W  = $clog2(DIV_N);
	localparam int NORM_SHIFT = 24;
	localparam int DIV_SHIFT  = 39;
	localparam int LITTLE     = -8388608;
	localparam int R_POS_MAX  = 32767;
	localparam int R_NEG_MAX  = 32768;

	localparam logic [1:0] REG_ALPHABET_LEN = 2'd0;
	localparam logic [1:0] REG_WIDTH_FIRST  = 2'd1;
	localparam logic [1:0] REG_WIDTH_SECOND = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MEAN_RD,
		ST_MEAN_ACC,
		ST_MEAN_GO,
		ST_MEAN_DIV,
		ST_PAIR_MU,
		ST_PAIR_RD,
		ST_PAIR_DX,
		ST_PAIR_MXY,
		ST_PAIR_MXX,
		ST_PAIR_MYY,
		ST_PAIR_CHK,
		ST_SQX,
		ST_SQY,
		ST_PAIR_MUL,
		ST_PAIR_DIV,
		ST_PAIR_ADD,
		ST_ALIGN_END,
		ST_FIN_GO,
		ST_FIN_DIV
	} state_t;

endpackage

/* hdl/mpc_sqrt.sv */
module mpc_sqrt import mpc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [SQ_W-1:0]       radicand,
	output logic                  done,
	output logic [SQ_W/2-1:0]     root
);

	logic [SQ_W-1:0]     v_q, r_q, bit_q, trial;
	logic [SQ_CNT_W-1:0] cnt_q;
	logic                run_q, done_q;
	logic                take;

	// digit-by-digit square root, two radicand bits a cycle
	assign trial = r_q + bit_q;
	assign take  = v_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q    <= '0;
			r_q    <= '0;
			bit_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			v_q    <= radicand;
			r_q    <= '0;
			bit_q  <= SQ_W'(1) << (SQ_W - 2);
			cnt_q  <= '0;
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			if (take) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == SQ_CNT_W'(SQ_STEPS - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign root = r_q[SQ_W/2-1:0];

endmodule

/* hdl/mpc_div.sv */
module mpc_div import mpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_N-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [DIV_N-1:0] quotient
);

	logic [DIV_N-1:0]     quo_q;
	logic [DEN_W:0]       rem_q, rem_sh;
	logic [DEN_W-1:0]     den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q, done_q;
	logic                 ge;

	// restoring division, one quotient bit a cycle
	assign rem_sh = {rem_q[DEN_W-1:0], quo_q[DIV_N-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			den_q  <= divisor;
			cnt_q  <= '0;
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[DIV_N-2:0], ge};
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_N - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* hdl/motif_pair_correlation.sv */
// channel   direction  handshake               payload
// item      in         start & !busy           which_motif column letter score last_entry
// result    out        done (one-cycle strobe) correlation zero_variance
// config    in         cfg_valid & cfg_ready   cfg_index cfg_data
//
// an item without last_entry is stored and busy stays low
// last_entry starts the pass; busy stays high until the pass ends, its length
//   set by the shared multiplier, the 32-step square root and the 80-step divider;
//   a pair with a flat column skips both square roots and the division
// reset is asynchronous and active low; matrix contents survive a new pass
// done strobes in the same cycle that busy falls; results cannot be stalled
`include "assert_macros.svh"

module motif_pair_correlation import mpc_pkg::*; #(
	parameter int MAX_WIDTH = 64,
	parameter int MAX_ALPH  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               which_motif,
	input  logic [5:0]         column,
	input  logic [4:0]         letter,
	input  logic signed [15:0] score,
	input  logic               last_entry,
	output logic               done,
	output logic signed [15:0] correlation,
	output logic               zero_variance,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_data
);

	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int CI_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int AL_W  = $clog2(MAX_ALPH + 1);
	localparam int LI_W  = $clog2(MAX_ALPH);
	localparam int DEPTH = MAX_WIDTH * MAX_ALPH;
	localparam int AW    = $clog2(DEPTH);
	localparam int MA_W  = $clog2(2 * MAX_WIDTH);
	localparam int ACC_W = 2 * DEV_W + LI_W;
	localparam int MS_W  = SCORE_W + AL_W + 2;
	localparam int SUM_W = (17 + CW > 24) ? 17 + CW : 24;

	state_t state_q, state_d;

	logic [5:0] alphabet_len_q;
	logic [6:0] width_first_q, width_second_q;
	logic [AL_W-1:0] alen_c;
	logic [CW-1:0]   wf_c, ws_c, w1_c, w2_c, minw_c, wmot_c;

	logic          mot_q, o_q;
	logic [CW-1:0] col_q, l_q, k_q, lk;
	logic [CW:0]   l_next, lk_next, k_next;
	logic [AL_W-1:0] n_q;
	logic          n_last;

	logic signed [15:0] mem_first_q [DEPTH];
	logic signed [15:0] mem_second_q [DEPTH];
	logic signed [15:0] rd_first_q, rd_second_q;
	logic signed [15:0] means_q [2*MAX_WIDTH];
	logic signed [15:0] mu1_q, mu2_q;
	logic          mem_we, mem_re, mean_we, mean_re;
	logic [AW-1:0] waddr, raddr_first, raddr_second;
	logic [CW-1:0] rcol_first, rcol_second;
	logic [MA_W-1:0] maddr_w, maddr_1, maddr_2;

	logic signed [15:0] samp_mean, samp_a, samp_b;
	logic signed [MS_W-1:0] s_q, mnum, mden, mmag;
	logic          mean_neg_q;
	logic signed [15:0] mean_val;

	logic signed [DEV_W-1:0]   dx_q, dy_q, mul_a, mul_b;
	logic signed [2*DEV_W-1:0] prod;
	logic signed [ACC_W-1:0]   sxy_q, sxx_q, syy_q, sxy_mag;
	logic                      sxy_neg, var_zero;
	logic [SQ_W/2-1:0]         nx_q, ny_q;
	logic signed [15:0]        r_q, r_val;
	logic signed [SUM_W-1:0]   rsum_q, best_q, best_mag;
	logic                      zero_q, done_q;
	logic signed [15:0]        corr_q;

	logic             div_start, div_done, sq_start, sq_done;
	logic [DIV_N-1:0] div_dividend, div_quot;
	logic [DEN_W-1:0] div_divisor;
	logic [SQ_W-1:0]  sq_radicand;
	logic [SQ_W/2-1:0] sq_root;

	function automatic logic [AW-1:0] ent_addr(input logic [CI_W-1:0] c,
		input logic [LI_W-1:0] n);
		return AW'(c) * AW'(MAX_ALPH) + AW'(n);
	endfunction

	function automatic logic [CW-1:0] clamp_w(input logic [6:0] v);
		if (v == 7'd0) return CW'(1);
		if (int'(v) > MAX_WIDTH) return CW'(MAX_WIDTH);
		return CW'(v);
	endfunction

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alphabet_len_q <= 6'd20;
			width_first_q  <= 7'd1;
			width_second_q <= 7'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ALPHABET_LEN: alphabet_len_q <= cfg_data[5:0];
				REG_WIDTH_FIRST:  width_first_q  <= cfg_data;
				REG_WIDTH_SECOND: width_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (alphabet_len_q == 6'd0) alen_c = AL_W'(1);
		else if (int'(alphabet_len_q) > MAX_ALPH) alen_c = AL_W'(MAX_ALPH);
		else alen_c = AL_W'(alphabet_len_q);
	end

	assign wf_c   = clamp_w(width_first_q);
	assign ws_c   = clamp_w(width_second_q);
	assign w1_c   = o_q ? ws_c : wf_c;
	assign w2_c   = o_q ? wf_c : ws_c;
	assign minw_c = (wf_c < ws_c) ? wf_c : ws_c;
	assign wmot_c = mot_q ? ws_c : wf_c;

	// loop bookkeeping
	assign lk      = l_q + k_q;
	assign l_next  = (CW+1)'(l_q) + 1'b1;
	assign lk_next = (CW+1)'(l_q) + (CW+1)'(k_q) + 1'b1;
	assign k_next  = (CW+1)'(k_q) + 1'b1;
	assign n_last  = n_q == alen_c - 1'b1;

	// matrix stores
	assign mem_we = (state_q == ST_IDLE) && start && (int'(column) < MAX_WIDTH)
		&& (int'(letter) < MAX_ALPH);
	assign waddr  = AW'(column) * AW'(MAX_ALPH) + AW'(letter);
	assign mem_re = (state_q == ST_MEAN_RD) || (state_q == ST_PAIR_RD);

	always_comb begin
		if (state_q == ST_MEAN_RD) begin
			rcol_first  = col_q;
			rcol_second = col_q;
		end else begin
			rcol_first  = o_q ? lk : l_q;
			rcol_second = o_q ? l_q : lk;
		end
	end

	assign raddr_first  = ent_addr(rcol_first[CI_W-1:0], n_q[LI_W-1:0]);
	assign raddr_second = ent_addr(rcol_second[CI_W-1:0], n_q[LI_W-1:0]);

	always_ff @(posedge clk) begin
		if (mem_we && !which_motif) mem_first_q[waddr] <= score;
		if (mem_we && which_motif) mem_second_q[waddr] <= score;
		if (mem_re) begin
			rd_first_q  <= mem_first_q[raddr_first];
			rd_second_q <= mem_second_q[raddr_second];
		end
	end

	// column means, first motif then second
	assign mean_we = (state_q == ST_MEAN_DIV) && div_done;
	assign mean_re = state_q == ST_PAIR_MU;
	assign maddr_w = mot_q ? MA_W'(MAX_WIDTH) + MA_W'(col_q[CI_W-1:0])
		: MA_W'(col_q[CI_W-1:0]);
	assign maddr_1 = o_q ? MA_W'(MAX_WIDTH) + MA_W'(l_q[CI_W-1:0])
		: MA_W'(l_q[CI_W-1:0]);
	assign maddr_2 = o_q ? MA_W'(lk[CI_W-1:0])
		: MA_W'(MAX_WIDTH) + MA_W'(lk[CI_W-1:0]);

	always_ff @(posedge clk) begin
		if (mean_we) means_q[maddr_w] <= mean_val;
		if (mean_re) begin
			mu1_q <= means_q[maddr_1];
			mu2_q <= means_q[maddr_2];
		end
	end

	assign samp_mean = mot_q ? rd_second_q : rd_first_q;
	assign samp_a    = o_q ? rd_second_q : rd_first_q;
	assign samp_b    = o_q ? rd_first_q : rd_second_q;

	// round to nearest, ties up: (2s + n) / 2n with floor
	assign mnum = (s_q <<< 1) + $signed(MS_W'(alen_c));
	assign mden = $signed(MS_W'(alen_c) << 1);
	assign mmag = (mnum < 0) ? -mnum + mden - MS_W'(1) : mnum;
	assign mean_val = mean_neg_q ? -$signed(div_quot[15:0]) : $signed(div_quot[15:0]);

	// shared multiplier for the three products of one letter
	always_comb begin
		case (state_q)
			ST_PAIR_MXX: begin
				mul_a = dx_q;
				mul_b = dx_q;
			end
			ST_PAIR_MYY: begin
				mul_a = dy_q;
				mul_b = dy_q;
			end
			default: begin
				mul_a = dx_q;
				mul_b = dy_q;
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	assign sxy_neg  = sxy_q[ACC_W-1];
	assign sxy_mag  = sxy_neg ? -sxy_q : sxy_q;
	assign var_zero = (sxx_q == '0) || (syy_q == '0);
	assign best_mag = best_q[SUM_W-1] ? -best_q : best_q;

	always_comb begin
		if (sxy_neg) begin
			if (div_quot >= DIV_N'(R_NEG_MAX)) r_val = -16'sd32768;
			else r_val = -$signed(div_quot[15:0]);
		end else begin
			if (div_quot >= DIV_N'(R_POS_MAX)) r_val = 16'sd32767;
			else r_val = $signed(div_quot[15:0]);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		sq_start     = 1'b0;
		sq_radicand  = '0;
		case (state_q)
			ST_IDLE: begin
				if (start && last_entry) state_d = ST_MEAN_RD;
			end
			ST_MEAN_RD: state_d = ST_MEAN_ACC;
			ST_MEAN_ACC: state_d = n_last ? ST_MEAN_GO : ST_MEAN_RD;
			ST_MEAN_GO: begin
				div_start    = 1'b1;
				div_dividend = DIV_N'($unsigned(mmag));
				div_divisor  = DEN_W'($unsigned(mden));
				state_d      = ST_MEAN_DIV;
			end
			ST_MEAN_DIV: begin
				if (div_done) begin
					if (col_q == wmot_c - 1'b1 && mot_q) state_d = ST_PAIR_MU;
					else state_d = ST_MEAN_RD;
				end
			end
			ST_PAIR_MU: state_d = ST_PAIR_RD;
			ST_PAIR_RD: state_d = ST_PAIR_DX;
			ST_PAIR_DX: state_d = ST_PAIR_MXY;
			ST_PAIR_MXY: state_d = ST_PAIR_MXX;
			ST_PAIR_MXX: state_d = ST_PAIR_MYY;
			ST_PAIR_MYY: state_d = n_last ? ST_PAIR_CHK : ST_PAIR_RD;
			ST_PAIR_CHK: begin
				if (var_zero) begin
					state_d = ST_PAIR_ADD;
				end else begin
					sq_start    = 1'b1;
					sq_radicand = SQ_W'($unsigned(sxx_q)) << NORM_SHIFT;
					state_d     = ST_SQX;
				end
			end
			ST_SQX: begin
				if (sq_done) begin
					sq_start    = 1'b1;
					sq_radicand = SQ_W'($unsigned(syy_q)) << NORM_SHIFT;
					state_d     = ST_SQY;
				end
			end
			ST_SQY: begin
				if (sq_done) state_d = ST_PAIR_MUL;
			end
			ST_PAIR_MUL: begin
				div_start    = 1'b1;
				div_dividend = DIV_N'($unsigned(sxy_mag)) << DIV_SHIFT;
				div_divisor  = DEN_W'(nx_q) * DEN_W'(ny_q);
				state_d      = ST_PAIR_DIV;
			end
			ST_PAIR_DIV: begin
				if (div_done) state_d = ST_PAIR_ADD;
			end
			ST_PAIR_ADD: begin
				if (l_next < (CW+1)'(w1_c) && lk_next < (CW+1)'(w2_c)) state_d = ST_PAIR_MU;
				else state_d = ST_ALIGN_END;
			end
			ST_ALIGN_END: begin
				if (k_next < (CW+1)'(w2_c) || !o_q) state_d = ST_PAIR_MU;
				else state_d = ST_FIN_GO;
			end
			ST_FIN_GO: begin
				div_start    = 1'b1;
				div_dividend = DIV_N'($unsigned(best_mag));
				div_divisor  = DEN_W'(minw_c);
				state_d      = ST_FIN_DIV;
			end
			ST_FIN_DIV: begin
				if (div_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mot_q      <= 1'b0;
			o_q        <= 1'b0;
			col_q      <= '0;
			l_q        <= '0;
			k_q        <= '0;
			n_q        <= '0;
			s_q        <= '0;
			mean_neg_q <= 1'b0;
			dx_q       <= '0;
			dy_q       <= '0;
			sxy_q      <= '0;
			sxx_q      <= '0;
			syy_q      <= '0;
			nx_q       <= '0;
			ny_q       <= '0;
			r_q        <= '0;
			rsum_q     <= '0;
			best_q     <= SUM_W'(LITTLE);
			zero_q     <= 1'b0;
			done_q     <= 1'b0;
			corr_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start && last_entry) begin
						mot_q  <= 1'b0;
						col_q  <= '0;
						n_q    <= '0;
						s_q    <= '0;
						zero_q <= 1'b0;
						best_q <= SUM_W'(LITTLE);
					end
				end
				ST_MEAN_ACC: begin
					s_q <= s_q + MS_W'(samp_mean);
					n_q <= n_q + 1'b1;
				end
				ST_MEAN_GO: mean_neg_q <= mnum < 0;
				ST_MEAN_DIV: begin
					if (div_done) begin
						s_q <= '0;
						n_q <= '0;
						if (col_q == wmot_c - 1'b1) begin
							col_q <= '0;
							mot_q <= 1'b1;
							// means done: set up the first alignment
							o_q    <= 1'b0;
							k_q    <= '0;
							l_q    <= '0;
							rsum_q <= '0;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				ST_PAIR_MU: begin
					sxy_q <= '0;
					sxx_q <= '0;
					syy_q <= '0;
					n_q   <= '0;
				end
				ST_PAIR_DX: begin
					dx_q <= $signed({samp_a[15], samp_a}) - $signed({mu1_q[15], mu1_q});
					dy_q <= $signed({samp_b[15], samp_b}) - $signed({mu2_q[15], mu2_q});
				end
				ST_PAIR_MXY: sxy_q <= sxy_q + ACC_W'(prod);
				ST_PAIR_MXX: sxx_q <= sxx_q + ACC_W'(prod);
				ST_PAIR_MYY: begin
					syy_q <= syy_q + ACC_W'(prod);
					n_q   <= n_q + 1'b1;
				end
				ST_PAIR_CHK: begin
					if (var_zero) begin
						zero_q <= 1'b1;
						r_q    <= '0;
					end
				end
				ST_SQX: begin
					if (sq_done) nx_q <= sq_root;
				end
				ST_SQY: begin
					if (sq_done) ny_q <= sq_root;
				end
				ST_PAIR_DIV: begin
					if (div_done) r_q <= r_val;
				end
				ST_PAIR_ADD: begin
					rsum_q <= rsum_q + SUM_W'(r_q);
					l_q    <= l_q + 1'b1;
				end
				ST_ALIGN_END: begin
					if (rsum_q > best_q) best_q <= rsum_q;
					rsum_q <= '0;
					l_q    <= '0;
					if (k_next < (CW+1)'(w2_c)) begin
						k_q <= k_q + 1'b1;
					end else if (!o_q) begin
						o_q <= 1'b1;
						k_q <= '0;
					end
				end
				ST_FIN_DIV: begin
					if (div_done) begin
						done_q <= 1'b1;
						corr_q <= best_q[SUM_W-1] ? -$signed(div_quot[15:0])
							: $signed(div_quot[15:0]);
					end
				end
				default: ;
			endcase
		end
	end

	mpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	mpc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_radicand),
		.done     (sq_done),
		.root     (sq_root)
	);

	assign busy          = state_q != ST_IDLE;
	assign done          = done_q;
	assign correlation   = corr_q;
	assign zero_variance = zero_q;

	`MPC_ASSERT(a_done_idle, done |-> !busy, "result strobe while busy")
	`MPC_ASSERT_NEXT(a_last_starts, start && !busy && last_entry, busy && !done,
		"last item did not start a pass")
	`MPC_ASSERT_NEXT(a_plain_load, start && !busy && !last_entry, !busy && !done,
		"plain item left the block busy")
	`MPC_ASSERT_NEXT(a_one_strobe, done, !done, "result strobe longer than one cycle")

endmodule
